@@ sv/clm_pkg.sv @@
// shared types and constants for the cpu load monitor
package clm_pkg;

    localparam int unsigned CNT_W   = 32;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned LOAD_W  = 8;
    localparam int unsigned NUM_W   = 39;   // work total times 100
    localparam int unsigned DEN_W   = 33;   // sleep plus work, one carry bit
    localparam int unsigned QUO_W   = 7;    // quotient never exceeds 100
    localparam int unsigned STEP_W  = 3;    // indexes quotient bits

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 104;

    localparam logic [OP_W-1:0] OP_SLEEP  = 2'd0;
    localparam logic [OP_W-1:0] OP_WAKE   = 2'd1;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

    localparam logic [LOAD_W-1:0] LOAD_FULL = 8'd100;
    localparam logic [LOAD_W-1:0] LOAD_NONE = 8'd255;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } clm_state_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

@@ sv/cpu_load_monitor.sv @@
// top level of the cpu load monitor: event handling, totals and report sequencer
//
// Busy/idle monitor. Each input transfer is an event stamped with a 32-bit
// free-running cycle count: sleep (0) adds the busy time since the last wake
// to the work total, bumps the sleep entry count and notes the sleep start;
// wake (1) adds the sleep time when asleep and restarts busy timing, and is
// ignored when already awake; report (2) returns one output transfer with the
// load percentage and the three totals, then clears the totals. Opcode 3 is
// ignored. All differences and totals wrap modulo 2^32. Load is
// floor(work*100/(sleep+work)), 100 when sleep is zero and 255 when both
// totals are zero. A report passes through capture, the restoring divider
// (one quotient bit per cycle through a single shared subtractor, the
// quotient being at most 100), the divider's done flag and the load of
// the output register; a report with a zero sleep total skips the divider.
// Either kind also stalls while the output register still holds an earlier
// report. The block takes no new event while a report is in flight, and the
// output register lets new sleep and wake events in while an earlier report
// still waits to be taken.
module cpu_load_monitor
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [clm_pkg::IN_DATA_W-1:0]      s_tdata,   // opcode[1:0], cycle_count[33:2]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [clm_pkg::OUT_DATA_W-1:0]     m_tdata    // load_percent[7:0], sleep_cycles[39:8],
                                                          // work_cycles[71:40], sleep_entries[103:72]
);

    logic [clm_pkg::OP_W-1:0]   opcode;
    logic [clm_pkg::CNT_W-1:0]  cycle_count;
    logic                       in_xfer;

    // running state
    logic [clm_pkg::CNT_W-1:0]  work_start_reg, work_start_next;
    logic [clm_pkg::CNT_W-1:0]  sleep_start_reg, sleep_start_next;
    logic [clm_pkg::CNT_W-1:0]  work_total_reg, work_total_next;
    logic [clm_pkg::CNT_W-1:0]  sleep_total_reg, sleep_total_next;
    logic [clm_pkg::CNT_W-1:0]  sleep_count_reg, sleep_count_next;
    logic                       awake_reg, awake_next;

    // report snapshot
    logic [clm_pkg::CNT_W-1:0]  snap_sleep_reg, snap_sleep_next;
    logic [clm_pkg::CNT_W-1:0]  snap_work_reg, snap_work_next;
    logic [clm_pkg::CNT_W-1:0]  snap_count_reg, snap_count_next;

    clm_pkg::clm_state_t        state_reg, state_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [clm_pkg::LOAD_W-1:0] out_load_reg, out_load_next;
    logic [clm_pkg::CNT_W-1:0]  out_sleep_reg, out_sleep_next;
    logic [clm_pkg::CNT_W-1:0]  out_work_reg, out_work_next;
    logic [clm_pkg::CNT_W-1:0]  out_count_reg, out_count_next;

    // divider hookup
    logic                       div_start;
    logic [clm_pkg::NUM_W-1:0]  div_num;
    logic [clm_pkg::DEN_W-1:0]  div_den;
    clm_pkg::div_sts_t          div_sts;
    logic [clm_pkg::QUO_W-1:0]  div_quo;

    logic                       out_free;
    logic [clm_pkg::LOAD_W-1:0] load_value;

    assign opcode      = s_tdata[clm_pkg::OP_W-1:0];
    assign cycle_count = s_tdata[clm_pkg::OP_W +: clm_pkg::CNT_W];
    assign s_tready    = (state_reg == clm_pkg::ST_IDLE);
    assign in_xfer     = s_tvalid && s_tready;
    assign out_free    = !out_valid_reg || m_tready;

    // work*100 as shifts and adds: 64 + 32 + 4
    assign div_num = {1'b0, work_total_reg, 6'b0}
                   + {2'b0, work_total_reg, 5'b0}
                   + {5'b0, work_total_reg, 2'b0};
    assign div_den = {1'b0, sleep_total_reg} + {1'b0, work_total_reg};

    // special cases decided from the snapshot
    always_comb
    begin
        if (snap_sleep_reg == '0)
        begin
            load_value = (snap_work_reg == '0) ? clm_pkg::LOAD_NONE : clm_pkg::LOAD_FULL;
        end
        else
        begin
            load_value = {1'b0, div_quo};
        end
    end

    always_comb
    begin
        work_start_next  = work_start_reg;
        sleep_start_next = sleep_start_reg;
        work_total_next  = work_total_reg;
        sleep_total_next = sleep_total_reg;
        sleep_count_next = sleep_count_reg;
        awake_next       = awake_reg;
        snap_sleep_next  = snap_sleep_reg;
        snap_work_next   = snap_work_reg;
        snap_count_next  = snap_count_reg;
        state_next       = state_reg;
        div_start        = 1'b0;
        out_valid_next   = out_valid_reg && !m_tready;
        out_load_next    = out_load_reg;
        out_sleep_next   = out_sleep_reg;
        out_work_next    = out_work_reg;
        out_count_next   = out_count_reg;

        case (state_reg)
            clm_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (opcode)
                        clm_pkg::OP_SLEEP:
                        begin
                            work_total_next  = work_total_reg + (cycle_count - work_start_reg);
                            sleep_count_next = sleep_count_reg + 1'b1;
                            sleep_start_next = cycle_count;
                            awake_next       = 1'b0;
                        end
                        clm_pkg::OP_WAKE:
                        begin
                            if (!awake_reg)
                            begin
                                awake_next       = 1'b1;
                                sleep_total_next = sleep_total_reg
                                                 + (cycle_count - sleep_start_reg);
                                work_start_next  = cycle_count;
                            end
                        end
                        clm_pkg::OP_REPORT:
                        begin
                            snap_sleep_next  = sleep_total_reg;
                            snap_work_next   = work_total_reg;
                            snap_count_next  = sleep_count_reg;
                            sleep_total_next = '0;
                            work_total_next  = '0;
                            sleep_count_next = '0;
                            // zero sleep total means no division is needed
                            if (sleep_total_reg != '0)
                            begin
                                div_start  = 1'b1;
                                state_next = clm_pkg::ST_DIV;
                            end
                            else
                            begin
                                state_next = clm_pkg::ST_DONE;
                            end
                        end
                        default:
                        begin
                            // unused opcode: no effect
                        end
                    endcase
                end
            end
            clm_pkg::ST_DIV:
            begin
                if (div_sts.done)
                begin
                    state_next = clm_pkg::ST_DONE;
                end
            end
            clm_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_load_next  = load_value;
                    out_sleep_next = snap_sleep_reg;
                    out_work_next  = snap_work_reg;
                    out_count_next = snap_count_reg;
                    state_next     = clm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = clm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_start_reg  <= '0;
            sleep_start_reg <= '0;
            work_total_reg  <= '0;
            sleep_total_reg <= '0;
            sleep_count_reg <= '0;
            awake_reg       <= 1'b1;
            state_reg       <= clm_pkg::ST_IDLE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            work_start_reg  <= work_start_next;
            sleep_start_reg <= sleep_start_next;
            work_total_reg  <= work_total_next;
            sleep_total_reg <= sleep_total_next;
            sleep_count_reg <= sleep_count_next;
            awake_reg       <= awake_next;
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_sleep_reg <= snap_sleep_next;
        snap_work_reg  <= snap_work_next;
        snap_count_reg <= snap_count_next;
        out_load_reg   <= out_load_next;
        out_sleep_reg  <= out_sleep_next;
        out_work_reg   <= out_work_next;
        out_count_reg  <= out_count_next;
    end

    clm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_work_reg, out_sleep_reg, out_load_reg};

    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && opcode == clm_pkg::OP_REPORT)
        |=> (work_total_reg == '0 && sleep_total_reg == '0 && sleep_count_reg == '0))
        else $error("totals not cleared after report");

    a_div_only_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.busy |-> (state_reg == clm_pkg::ST_DIV))
        else $error("divider running outside the divide state");

    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_load_reg <= clm_pkg::LOAD_FULL
                           || out_load_reg == clm_pkg::LOAD_NONE))
        else $error("load percentage out of range");

    a_no_sleep_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sleep_reg == '0)
        |-> (out_load_reg == clm_pkg::LOAD_FULL || out_load_reg == clm_pkg::LOAD_NONE))
        else $error("load wrong for zero sleep total");

endmodule

@@ sv/clm_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module clm_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [clm_pkg::NUM_W-1:0]     num,
    input  logic [clm_pkg::DEN_W-1:0]     den,
    output clm_pkg::div_sts_t             sts,
    output logic [clm_pkg::QUO_W-1:0]     quotient
);

    logic [clm_pkg::NUM_W-1:0]   rem_reg, rem_next;
    logic [clm_pkg::DEN_W-1:0]   den_reg, den_next;
    logic [clm_pkg::QUO_W-1:0]   quo_reg, quo_next;
    logic [clm_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [clm_pkg::NUM_W:0]     trial;

    // shared subtractor: remainder minus shifted divisor
    assign trial = {1'b0, rem_reg}
                 - ({{(clm_pkg::NUM_W + 1 - clm_pkg::DEN_W){1'b0}}, den_reg} << step_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            quo_next  = '0;
            step_next = clm_pkg::STEP_W'(clm_pkg::QUO_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[clm_pkg::NUM_W])
            begin
                rem_next           = trial[clm_pkg::NUM_W-1:0];
                quo_next[step_reg] = 1'b1;
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not go busy after start");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_done_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && step_reg == '0) |=> done_reg)
        else $error("divider missed its last step");

endmodule
